>>> rtl/core/spct_pkg.sv
// shared types and codes for the shape pair collision test
`default_nettype none
package spct_pkg;

  // shape kind codes
  localparam logic [1:0] KIND_RECT     = 2'd0;
  localparam logic [1:0] KIND_CIRCLE   = 2'd1;
  localparam logic [1:0] KIND_POLYGON  = 2'd2;
  localparam logic [1:0] KIND_TRIANGLE = 2'd3;

  localparam int unsigned VTX_W = 32;

  // one stored vertex, x in the low half
  typedef struct packed {
    logic signed [15:0] y;
    logic signed [15:0] x;
  } vtx_t;

  // per-shape scalar state handed to the evaluator
  typedef struct packed {
    logic [1:0]  kind;
    vtx_t        maxc;
    logic [14:0] radius;
  } shape_t;

  // axis-aligned box
  typedef struct packed {
    logic signed [15:0] x0;
    logic signed [15:0] x1;
    logic signed [15:0] y0;
    logic signed [15:0] y1;
  } box_t;

endpackage
`default_nettype wire

>>> rtl/core/spct_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module spct_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/spct_eval.sv
// evaluation sequencer: walks the vertex memories and decides the collision
`default_nettype none
module spct_eval #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire spct_pkg::shape_t                  shape_a,
  input  wire spct_pkg::shape_t                  shape_b,
  input  wire logic [$clog2(MAX_VERTICES+1)-1:0] cnt_a,
  input  wire logic [$clog2(MAX_VERTICES+1)-1:0] cnt_b,
  output logic      [$clog2(MAX_VERTICES)-1:0]   rd_addr,
  input  wire spct_pkg::vtx_t                    rd_a,
  input  wire spct_pkg::vtx_t                    rd_b,
  output logic                                   busy,
  output logic                                   res_valid,
  output logic                                   res_data,
  input  wire logic                              res_ready
);

  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AW = $clog2(MAX_VERTICES);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_LD0   = 13'b0000000000010,
    ST_LD1   = 13'b0000000000100,
    ST_BB_RD = 13'b0000000001000,
    ST_BB_UP = 13'b0000000010000,
    ST_X_RD  = 13'b0000000100000,
    ST_X_DIF = 13'b0000001000000,
    ST_X_MUL = 13'b0000010000000,
    ST_X_CMP = 13'b0000100000000,
    ST_F_DIF = 13'b0001000000000,
    ST_F_MUL = 13'b0010000000000,
    ST_F_CMP = 13'b0100000000000,
    ST_SPARE = 13'b1000000000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    sel_r, sel_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [1:0]              corner_r, corner_nxt;
  logic                    par_r, par_nxt;
  logic                    hit_r, hit_nxt;
  spct_pkg::box_t          box_a_r, box_a_nxt, box_b_r, box_b_nxt;
  spct_pkg::vtx_t          prev_r, prev_nxt;
  logic                    cond_r, cond_nxt, dpos_r, dpos_nxt;
  logic signed [16:0]      fa_r, fa_nxt, fd_r, fd_nxt, fb_r, fb_nxt, fc_r, fc_nxt;
  logic signed [33:0]      lhs_r, lhs_nxt, rhs_r, rhs_nxt;
  logic signed [16:0]      dx_r, dx_nxt, dy_r, dy_nxt;
  logic [15:0]             rr_r, rr_nxt;
  logic [33:0]             dx2_r, dx2_nxt, dy2_r, dy2_nxt;
  logic [31:0]             r2_r, r2_nxt;

  logic                    a_rect, a_circ, a_poly, b_rect, b_circ, b_poly, rp_pair;
  logic [CW-1:0]           cnt_cur, cnt_m1, idx_p1;
  spct_pkg::vtx_t          vin;
  spct_pkg::box_t          cur_box, oth_box, circ_box;
  spct_pkg::shape_t        circ_shape;
  logic signed [15:0]      px, py, cxc, cyc;
  logic signed [16:0]      yi_ext, yj_ext;
  logic                    left, in_rect, overlap, circ_hit;
  logic signed [33:0]      pa_full, pb_full, sqx, sqy;
  logic [34:0]             dsum;

  // shape classes
  assign a_rect  = shape_a.kind == spct_pkg::KIND_RECT;
  assign a_circ  = shape_a.kind == spct_pkg::KIND_CIRCLE;
  assign a_poly  = shape_a.kind[1];
  assign b_rect  = shape_b.kind == spct_pkg::KIND_RECT;
  assign b_circ  = shape_b.kind == spct_pkg::KIND_CIRCLE;
  assign b_poly  = shape_b.kind[1];
  assign rp_pair = (a_rect && b_poly) || (a_poly && b_rect);

  // walk bookkeeping for the selected shape
  assign cnt_cur = sel_r ? cnt_b : cnt_a;
  assign cnt_m1  = cnt_cur - 1'b1;
  assign idx_p1  = idx_r + 1'b1;
  assign vin     = sel_r ? rd_b : rd_a;
  assign cur_box = sel_r ? box_b_r : box_a_r;
  assign oth_box = sel_r ? box_a_r : box_b_r;

  // read address for the memories
  always_comb begin
    rd_addr = '0;
    if (state_r == ST_BB_RD) begin
      rd_addr = idx_r[AW-1:0];
    end else if (state_r == ST_X_RD) begin
      rd_addr = (idx_r == '0) ? cnt_m1[AW-1:0] : idx_r[AW-1:0] - 1'b1;
    end
  end

  // rectangle corner under test
  assign px = (corner_r == 2'd1 || corner_r == 2'd2) ? oth_box.x1 : oth_box.x0;
  assign py = corner_r[1] ? oth_box.y1 : oth_box.y0;
  assign yi_ext = 17'(vin.y);
  assign yj_ext = 17'(prev_r.y);

  // vertex inside the other shape's rectangle
  assign in_rect = (vin.x >= oth_box.x0) && (vin.x <= oth_box.x1) &&
                   (vin.y >= oth_box.y0) && (vin.y <= oth_box.y1);

  // crossing products and side decision
  assign pa_full = fa_r * fd_r;
  assign pb_full = fb_r * fc_r;
  assign left    = dpos_r ? (lhs_r < rhs_r) : (lhs_r > rhs_r);

  // circle against box clamp
  assign circ_shape = a_circ ? shape_a : shape_b;
  assign circ_box   = a_circ ? box_a_r : box_b_r;
  always_comb begin
    spct_pkg::box_t ob;
    ob  = a_circ ? box_b_r : box_a_r;
    cxc = (circ_box.x0 < ob.x1) ? circ_box.x0 : ob.x1;
    cxc = (ob.x0 > cxc) ? ob.x0 : cxc;
    cyc = (circ_box.y0 < ob.y1) ? circ_box.y0 : ob.y1;
    cyc = (ob.y0 > cyc) ? ob.y0 : cyc;
  end

  assign sqx      = dx_r * dx_r;
  assign sqy      = dy_r * dy_r;
  assign dsum     = {1'b0, dx2_r} + {1'b0, dy2_r};
  assign circ_hit = dsum <= {3'b000, r2_r};
  assign overlap  = !(box_a_r.x1 < box_b_r.x0 || box_a_r.x0 > box_b_r.x1 ||
                      box_a_r.y1 < box_b_r.y0 || box_a_r.y0 > box_b_r.y1);

  assign busy      = state_r != ST_IDLE;
  assign res_valid = state_r == ST_F_CMP;
  assign res_data  = (a_circ || b_circ) ? circ_hit : (overlap || hit_r);

  // sequencer next state
  always_comb begin
    logic pt;
    state_nxt  = state_r;
    sel_nxt    = sel_r;
    idx_nxt    = idx_r;
    corner_nxt = corner_r;
    par_nxt    = par_r;
    hit_nxt    = hit_r;
    box_a_nxt  = box_a_r;
    box_b_nxt  = box_b_r;
    prev_nxt   = prev_r;
    cond_nxt   = cond_r;
    dpos_nxt   = dpos_r;
    fa_nxt     = fa_r;
    fd_nxt     = fd_r;
    fb_nxt     = fb_r;
    fc_nxt     = fc_r;
    lhs_nxt    = lhs_r;
    rhs_nxt    = rhs_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    rr_nxt     = rr_r;
    dx2_nxt    = dx2_r;
    dy2_nxt    = dy2_r;
    r2_nxt     = r2_r;
    pt         = par_r ^ (cond_r && left);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LD0;
        end
      end
      ST_LD0: begin
        state_nxt = ST_LD1;
      end
      // first entries give rectangles, circle centers and box seeds
      ST_LD1: begin
        box_a_nxt.x0 = rd_a.x;
        box_a_nxt.y0 = rd_a.y;
        box_a_nxt.x1 = a_rect ? shape_a.maxc.x : rd_a.x;
        box_a_nxt.y1 = a_rect ? shape_a.maxc.y : rd_a.y;
        box_b_nxt.x0 = rd_b.x;
        box_b_nxt.y0 = rd_b.y;
        box_b_nxt.x1 = b_rect ? shape_b.maxc.x : rd_b.x;
        box_b_nxt.y1 = b_rect ? shape_b.maxc.y : rd_b.y;
        hit_nxt = 1'b0;
        par_nxt = 1'b0;
        idx_nxt = '0;
        if (a_poly) begin
          sel_nxt   = 1'b0;
          state_nxt = ST_BB_RD;
        end else if (b_poly) begin
          sel_nxt   = 1'b1;
          state_nxt = ST_BB_RD;
        end else begin
          state_nxt = ST_F_DIF;
        end
      end
      ST_BB_RD: begin
        state_nxt = ST_BB_UP;
      end
      // bounding box and vertex-in-rectangle walk
      ST_BB_UP: begin
        if (sel_r) begin
          box_b_nxt.x0 = (vin.x < cur_box.x0) ? vin.x : cur_box.x0;
          box_b_nxt.x1 = (vin.x > cur_box.x1) ? vin.x : cur_box.x1;
          box_b_nxt.y0 = (vin.y < cur_box.y0) ? vin.y : cur_box.y0;
          box_b_nxt.y1 = (vin.y > cur_box.y1) ? vin.y : cur_box.y1;
        end else begin
          box_a_nxt.x0 = (vin.x < cur_box.x0) ? vin.x : cur_box.x0;
          box_a_nxt.x1 = (vin.x > cur_box.x1) ? vin.x : cur_box.x1;
          box_a_nxt.y0 = (vin.y < cur_box.y0) ? vin.y : cur_box.y0;
          box_a_nxt.y1 = (vin.y > cur_box.y1) ? vin.y : cur_box.y1;
        end
        if (rp_pair && in_rect) begin
          hit_nxt = 1'b1;
        end
        idx_nxt   = idx_p1;
        state_nxt = ST_BB_RD;
        if (idx_p1 >= cnt_cur) begin
          idx_nxt = '0;
          if (!sel_r && b_poly) begin
            sel_nxt = 1'b1;
          end else if (rp_pair) begin
            corner_nxt = 2'd0;
            state_nxt  = ST_X_RD;
          end else begin
            state_nxt = ST_F_DIF;
          end
        end
      end
      ST_X_RD: begin
        state_nxt = ST_X_DIF;
      end
      // edge setup for the crossing test
      ST_X_DIF: begin
        prev_nxt = vin;
        if (idx_r == '0) begin
          idx_nxt   = idx_p1;
          state_nxt = ST_X_RD;
        end else begin
          cond_nxt  = (vin.y > py) != (prev_r.y > py);
          fd_nxt    = yj_ext - yi_ext;
          dpos_nxt  = yj_ext > yi_ext;
          fa_nxt    = 17'(px) - 17'(vin.x);
          fb_nxt    = 17'(prev_r.x) - 17'(vin.x);
          fc_nxt    = 17'(py) - yi_ext;
          state_nxt = ST_X_MUL;
        end
      end
      ST_X_MUL: begin
        lhs_nxt   = pa_full;
        rhs_nxt   = pb_full;
        state_nxt = ST_X_CMP;
      end
      // parity update, next edge or next corner
      ST_X_CMP: begin
        par_nxt   = pt;
        idx_nxt   = idx_p1;
        state_nxt = ST_X_RD;
        if (idx_r >= cnt_cur) begin
          hit_nxt = hit_r | pt;
          par_nxt = 1'b0;
          idx_nxt = '0;
          if (corner_r == 2'd3) begin
            state_nxt = ST_F_DIF;
          end else begin
            corner_nxt = corner_r + 1'b1;
          end
        end
      end
      // distance terms for circle pairings
      ST_F_DIF: begin
        if (a_circ && b_circ) begin
          dx_nxt = 17'(box_a_r.x0) - 17'(box_b_r.x0);
          dy_nxt = 17'(box_a_r.y0) - 17'(box_b_r.y0);
          rr_nxt = 16'(shape_a.radius) + 16'(shape_b.radius);
        end else begin
          dx_nxt = 17'(circ_box.x0) - 17'(cxc);
          dy_nxt = 17'(circ_box.y0) - 17'(cyc);
          rr_nxt = 16'(circ_shape.radius);
        end
        state_nxt = ST_F_MUL;
      end
      ST_F_MUL: begin
        dx2_nxt   = sqx;
        dy2_nxt   = sqy;
        r2_nxt    = rr_r * rr_r;
        state_nxt = ST_F_CMP;
      end
      ST_F_CMP: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    sel_r    <= sel_nxt;
    idx_r    <= idx_nxt;
    corner_r <= corner_nxt;
    par_r    <= par_nxt;
    hit_r    <= hit_nxt;
    box_a_r  <= box_a_nxt;
    box_b_r  <= box_b_nxt;
    prev_r   <= prev_nxt;
    cond_r   <= cond_nxt;
    dpos_r   <= dpos_nxt;
    fa_r     <= fa_nxt;
    fd_r     <= fd_nxt;
    fb_r     <= fb_nxt;
    fc_r     <= fc_nxt;
    lhs_r    <= lhs_nxt;
    rhs_r    <= rhs_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    rr_r     <= rr_nxt;
    dx2_r    <= dx2_nxt;
    dy2_r    <= dy2_nxt;
    r2_r     <= r2_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/core/shape_pair_collision_test_unit.sv
// top level: shape loading, vertex memories, evaluator and result register
//
//  channel | dir | handshake         | content
//  in_     | in  | tvalid/tready     | one shape element (tdata, tuser, tlast)
//  out_    | out | tvalid/tready     | collided bit
//
// loading accepts items while the evaluator is idle; an item that completes the second shape
// starts an evaluation: a box walk per polygon, a crossing test of the four rectangle corners
// for a rectangle/polygon pair, then the final compare.
// every walk goes through the single read port of the vertex memories.
// reset clears shape kinds, counts and open flags; memories are not cleared.
// input is stalled during an evaluation; a waiting result is held in the output register.
`default_nettype none
module shape_pair_collision_test_unit #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [15:0] point_x, [31:16] point_y, [47:32] corner_max_x, [63:48] corner_max_y,
  // [78:64] radius, [79] zero
  input  wire logic [79:0] in_tdata,
  // [0] req_type, [2:1] shape_kind
  input  wire logic [2:0]  in_tuser,
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] collided, [7:1] zero
  output logic [7:0]       out_tdata
);

  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AW = $clog2(MAX_VERTICES);

  spct_pkg::shape_t shape_r [2];
  logic [CW-1:0]    cnt_r   [2];
  logic             open_r  [2];

  logic             accept, side, is_poly, busy, start;
  logic [1:0]       kind_in;
  logic [CW-1:0]    eff_cnt, cnt_nxt;
  logic             room, wr_en, open_nxt, complete;
  logic [AW-1:0]    wr_addr, rd_addr;
  spct_pkg::vtx_t   wr_vtx, rd_a, rd_b;
  logic             res_valid, res_data, res_ready;
  logic             out_valid_r, coll_r;

  assign in_tready = !busy;
  assign accept    = in_tvalid && in_tready;
  assign side      = in_tuser[0];
  assign kind_in   = in_tuser[2:1];
  assign is_poly   = kind_in[1];

  // element placement for the addressed shape
  assign eff_cnt  = open_r[side] ? cnt_r[side] : '0;
  assign room     = eff_cnt < CW'(MAX_VERTICES);
  assign wr_addr  = is_poly ? eff_cnt[AW-1:0] : '0;
  assign wr_en    = accept && (!is_poly || room);
  assign cnt_nxt  = !is_poly ? CW'(1) : (room ? eff_cnt + 1'b1 : eff_cnt);
  assign open_nxt = is_poly && !in_tlast;
  assign complete = !is_poly || in_tlast;
  assign start    = accept && side && complete;
  assign wr_vtx   = spct_pkg::vtx_t'(in_tdata[31:0]);

  // shape scalar state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        shape_r[i] <= '0;
        cnt_r[i]   <= '0;
        open_r[i]  <= 1'b0;
      end
    end else if (accept) begin
      shape_r[side].kind   <= kind_in;
      shape_r[side].maxc   <= spct_pkg::vtx_t'(in_tdata[63:32]);
      shape_r[side].radius <= in_tdata[78:64];
      cnt_r[side]          <= cnt_nxt;
      open_r[side]         <= open_nxt;
    end
  end

  // vertex memories
  spct_ram #(.WIDTH(spct_pkg::VTX_W), .DEPTH(MAX_VERTICES)) u_ram_a (
    .clk   (clk),
    .we    (wr_en && !side),
    .waddr (wr_addr),
    .wdata (wr_vtx),
    .raddr (rd_addr),
    .rdata (rd_a)
  );

  spct_ram #(.WIDTH(spct_pkg::VTX_W), .DEPTH(MAX_VERTICES)) u_ram_b (
    .clk   (clk),
    .we    (wr_en && side),
    .waddr (wr_addr),
    .wdata (wr_vtx),
    .raddr (rd_addr),
    .rdata (rd_b)
  );

  // collision evaluator
  spct_eval #(.MAX_VERTICES(MAX_VERTICES)) u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .shape_a   (shape_r[0]),
    .shape_b   (shape_r[1]),
    .cnt_a     (cnt_r[0]),
    .cnt_b     (cnt_r[1]),
    .rd_addr   (rd_addr),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .busy      (busy),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      coll_r <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0000000, coll_r};

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// testbench for the shape pair collision test unit: random shape pairs checked against a predictor
`timescale 1ns / 1ps
module tb_top;

  localparam int NV = 16;

  typedef struct {
    logic [79:0] data;
    logic [2:0]  user;
    logic        last;
    int          gap;
  } elem_t;

  typedef struct {
    logic [1:0]         kind;
    int                 cnt;
    logic               open;
    logic signed [15:0] vx [NV];
    logic signed [15:0] vy [NV];
    logic signed [15:0] mxx, mxy;
    longint             rad;
  } shp_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  elem_t  pending_items[$];
  logic   expected_hits[$];
  shp_t   shp[2];
  int     errors = 0;
  int     gap_left;
  int     stall_left;
  int     ready_wait;
  int     hold_cycles;
  logic   stim_done;
  logic   drain_wait;

  shape_pair_collision_test_unit #(.MAX_VERTICES(NV)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // point strictly inside by crossing parity
  function automatic logic cross_inside(longint px, longint py, shp_t p);
    logic   ins;
    int     j;
    longint xi, yi, xj, yj, d, lhs, rhs;
    ins = 1'b0;
    if (p.cnt == 0) return 1'b0;
    j = p.cnt - 1;
    for (int i = 0; i < p.cnt; i++) begin
      xi = p.vx[i]; yi = p.vy[i]; xj = p.vx[j]; yj = p.vy[j];
      if ((yi > py) != (yj > py)) begin
        d = yj - yi;
        lhs = (px - xi) * d;
        rhs = (xj - xi) * (py - yi);
        if (d > 0 ? (lhs < rhs) : (lhs > rhs)) ins = ~ins;
      end
      j = i;
    end
    return ins;
  endfunction

  function automatic void poly_box(shp_t p, output longint x0, x1, y0, y1);
    x0 = p.vx[0]; x1 = p.vx[0]; y0 = p.vy[0]; y1 = p.vy[0];
    for (int i = 0; i < p.cnt; i++) begin
      if (p.vx[i] < x0) x0 = p.vx[i];
      if (p.vx[i] > x1) x1 = p.vx[i];
      if (p.vy[i] < y0) y0 = p.vy[i];
      if (p.vy[i] > y1) y1 = p.vy[i];
    end
  endfunction

  function automatic logic clamp_hit(longint x0, x1, y0, y1, shp_t c);
    longint cx, cy, dx, dy;
    cx = c.vx[0] < x1 ? c.vx[0] : x1;
    cx = cx > x0 ? cx : x0;
    cy = c.vy[0] < y1 ? c.vy[0] : y1;
    cy = cy > y0 ? cy : y0;
    dx = c.vx[0] - cx; dy = c.vy[0] - cy;
    return dx * dx + dy * dy <= c.rad * c.rad;
  endfunction

  function automatic logic rect_poly_hit(shp_t r, shp_t p);
    longint x0, x1, y0, y1;
    if (cross_inside(r.vx[0], r.vy[0], p) || cross_inside(r.mxx, r.vy[0], p) ||
        cross_inside(r.mxx, r.mxy, p) || cross_inside(r.vx[0], r.mxy, p)) return 1'b1;
    for (int i = 0; i < p.cnt; i++)
      if (p.vx[i] >= r.vx[0] && p.vx[i] <= r.mxx && p.vy[i] >= r.vy[0] && p.vy[i] <= r.mxy)
        return 1'b1;
    poly_box(p, x0, x1, y0, y1);
    return !(r.vx[0] > x1 || r.mxx < x0 || r.vy[0] > y1 || r.mxy < y0);
  endfunction

  function automatic logic shapes_overlap(shp_t a, shp_t b);
    int     ka, kb;
    longint ax0, ax1, ay0, ay1, bx0, bx1, by0, by1, dx, dy, rs;
    ka = a.kind >= spct_pkg::KIND_POLYGON ? 2 : a.kind;
    kb = b.kind >= spct_pkg::KIND_POLYGON ? 2 : b.kind;
    if (ka == 0 && kb == 0)
      return !(a.mxx < b.vx[0] || a.vx[0] > b.mxx || a.mxy < b.vy[0] || a.vy[0] > b.mxy);
    if (ka == 0 && kb == 1) return clamp_hit(a.vx[0], a.mxx, a.vy[0], a.mxy, b);
    if (ka == 1 && kb == 0) return clamp_hit(b.vx[0], b.mxx, b.vy[0], b.mxy, a);
    if (ka == 0) return rect_poly_hit(a, b);
    if (kb == 0) return rect_poly_hit(b, a);
    if (ka == 1 && kb == 1) begin
      dx = a.vx[0] - b.vx[0]; dy = a.vy[0] - b.vy[0]; rs = a.rad + b.rad;
      return dx * dx + dy * dy <= rs * rs;
    end
    if (ka == 1) begin
      poly_box(b, bx0, bx1, by0, by1);
      return clamp_hit(bx0, bx1, by0, by1, a);
    end
    if (kb == 1) begin
      poly_box(a, ax0, ax1, ay0, ay1);
      return clamp_hit(ax0, ax1, ay0, ay1, b);
    end
    poly_box(a, ax0, ax1, ay0, ay1);
    poly_box(b, bx0, bx1, by0, by1);
    return !(ax1 < bx0 || ax0 > bx1 || ay1 < by0 || ay0 > by1);
  endfunction

  // update shape state with one item, queue a collided bit when due
  function automatic void load_shape(elem_t e);
    int         s;
    logic [1:0] k;
    logic       done;
    s = e.user[0];
    k = e.user[2:1];
    done = 1'b0;
    shp[s].kind = k;
    shp[s].mxx = e.data[47:32];
    shp[s].mxy = e.data[63:48];
    shp[s].rad = e.data[78:64];
    if (k == spct_pkg::KIND_RECT || k == spct_pkg::KIND_CIRCLE) begin
      shp[s].vx[0] = e.data[15:0];
      shp[s].vy[0] = e.data[31:16];
      shp[s].cnt = 1;
      shp[s].open = 1'b0;
      done = 1'b1;
    end else begin
      if (!shp[s].open) begin
        shp[s].cnt = 0;
        shp[s].open = 1'b1;
      end
      if (shp[s].cnt < NV) begin
        shp[s].vx[shp[s].cnt] = e.data[15:0];
        shp[s].vy[shp[s].cnt] = e.data[31:16];
        shp[s].cnt++;
      end
      if (e.last) begin
        shp[s].open = 1'b0;
        done = 1'b1;
      end
    end
    if (done && s == 1) expected_hits.push_back(shapes_overlap(shp[0], shp[1]));
  endfunction

  function automatic logic [15:0] rnd_coord(int mode);
    case (mode)
      0: return 16'(-32768 + $urandom_range(0, 1) * 65535);
      1: return 16'($urandom_range(0, 200) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  // queue one element
  task automatic add_elem(input logic side, input logic [1:0] k, input logic [15:0] px,
                          input logic [15:0] py, input logic [15:0] qx, input logic [15:0] qy,
                          input logic [14:0] r, input logic lst, input int gap);
    elem_t e;
    e.data = {1'b0, r, qy, qx, py, px};
    e.user = {k, side};
    e.last = lst;
    e.gap = gap;
    pending_items.push_back(e);
  endtask

  // queue a random shape; polygons are closed unless told otherwise
  task automatic add_shape(input logic side, input int mode, input logic close_it);
    logic [1:0] k;
    int         n;
    logic [15:0] x, y;
    k = 2'($urandom_range(0, 3));
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 8);
    if (k == spct_pkg::KIND_RECT || k == spct_pkg::KIND_CIRCLE) begin
      x = rnd_coord(mode); y = rnd_coord(mode);
      add_elem(side, k, x, y,
               ($urandom_range(0, 9) == 0) ? rnd_coord(2) : 16'(x + $urandom_range(0, 80)),
               ($urandom_range(0, 9) == 0) ? rnd_coord(2) : 16'(y + $urandom_range(0, 80)),
               (mode == 1) ? 15'($urandom_range(0, 90)) : 15'($urandom),
               1'($urandom), $urandom_range(0, 18) * $urandom_range(0, 1));
    end else begin
      for (int i = 0; i < n; i++)
        add_elem(side, ($urandom_range(0, 1) ? spct_pkg::KIND_POLYGON : spct_pkg::KIND_TRIANGLE),
                 rnd_coord(mode), rnd_coord(mode), rnd_coord(2), rnd_coord(2),
                 15'($urandom), close_it && (i == n - 1),
                 $urandom_range(0, 18) * $urandom_range(0, 1));
    end
  endtask

  // stimulus
  initial begin
    logic [15:0] mn, mxv;
    for (int s = 0; s < 2; s++) begin
      shp[s].kind = spct_pkg::KIND_RECT; shp[s].cnt = 0; shp[s].open = 1'b0;
      shp[s].mxx = 0; shp[s].mxy = 0; shp[s].rad = 0;
      for (int i = 0; i < NV; i++) begin
        shp[s].vx[i] = 0; shp[s].vy[i] = 0;
      end
    end
    mn = 16'h8000; mxv = 16'h7fff;
    // directed: extremes, every pairing, inverted rect, kind change, overflow
    add_elem(0, spct_pkg::KIND_RECT, mn, mn, mxv, mxv, 15'h7fff, 0, 0);
    add_elem(1, spct_pkg::KIND_RECT, mxv, mxv, mn, mn, 15'h0, 0, 0);
    add_elem(1, spct_pkg::KIND_CIRCLE, mn, mxv, 0, 0, 15'h7fff, 1, 0);
    add_elem(0, spct_pkg::KIND_CIRCLE, mxv, mn, mxv, mn, 15'h7fff, 1, 0);
    add_elem(1, spct_pkg::KIND_CIRCLE, mn, mxv, mn, mxv, 15'h7fff, 0, 0);
    add_elem(1, spct_pkg::KIND_POLYGON, 0, 0, 0, 0, 0, 0, 0);
    add_elem(1, spct_pkg::KIND_TRIANGLE, 100, 0, 0, 0, 0, 0, 0);
    add_elem(1, spct_pkg::KIND_POLYGON, 0, 100, 0, 0, 0, 1, 0);
    add_elem(0, spct_pkg::KIND_RECT, 10, 10, 20, 20, 0, 1, 0);
    add_elem(1, spct_pkg::KIND_TRIANGLE, 0, 0, 0, 0, 0, 0, 0);
    add_elem(1, spct_pkg::KIND_TRIANGLE, 100, 0, 0, 0, 0, 0, 0);
    add_elem(1, spct_pkg::KIND_TRIANGLE, 0, 100, 0, 0, 0, 1, 0);
    for (int i = 0; i < 18; i++)
      add_elem(0, spct_pkg::KIND_POLYGON, 16'(i * 7), 16'(i * 3), 0, 0, 0, i == 17, 0);
    add_elem(1, spct_pkg::KIND_POLYGON, mn, mn, 0, 0, 0, 0, 0);
    add_elem(1, spct_pkg::KIND_POLYGON, mxv, mxv, 0, 0, 0, 1, 0);
    // random: mostly full pairs, some open first shapes and stray polygons
    while (pending_items.size() < 700) begin
      if ($urandom_range(0, 7) != 0) add_shape(0, $urandom_range(0, 3) ? 1 : 2,
                                                $urandom_range(0, 9) != 0);
      add_shape(1, $urandom_range(0, 3) ? 1 : 2, 1'b1);
    end
  end

  // reset
  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver: gaps and a drain pause
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0; in_tdata <= '0; in_tuser <= '0; in_tlast <= 1'b0;
      gap_left <= 0;
      stim_done <= 1'b0;
      drain_wait <= 1'b0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid && in_tready) load_shape(pending_items.pop_front());
      if (pending_items.size() == 300 && !drain_wait && expected_hits.size() != 0) begin
        in_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        in_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() != 0 && !(in_tvalid && in_tready && pending_items[0].gap != 0)) begin
        if (pending_items.size() == 300) drain_wait <= 1'b1;
        in_tvalid <= 1'b1;
        in_tdata <= pending_items[0].data;
        in_tuser <= pending_items[0].user;
        in_tlast <= pending_items[0].last;
      end else begin
        in_tvalid <= 1'b0;
        if (pending_items.size() != 0) gap_left <= pending_items[0].gap - 1;
        else stim_done <= 1'b1;
      end
    end
  end

  // monitor: receiver stalls and checking
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      hold_cycles <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time, out_tdata[0]);
          errors++;
        end else begin
          logic e;
          e = expected_hits.pop_front();
          if (out_tdata !== {7'd0, e}) begin
            $display("%0t: collided mismatch, expected %0d, actual %0h", $time, e, out_tdata);
            errors++;
          end
        end
      end
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles >= 2000 && hold_cycles < 2600) begin
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (out_tvalid && out_tready) begin
        ready_wait = $urandom_range(0, 18);
        if (ready_wait != 0) begin
          out_tready <= 1'b0;
          stall_left <= ready_wait - 1;
        end else begin
          out_tready <= 1'b1;
        end
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done === 1'b1);
    wait (expected_hits.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/spct_pkg.sv
rtl/core/spct_ram.sv
rtl/core/spct_eval.sv
rtl/core/shape_pair_collision_test_unit.sv
sim/tb_top.sv
